### hdl/crsm_pkg.sv
package crsm_pkg;

   // Field widths
   localparam int TS_W   = 32;
   localparam int TEMP_W = 17;
   localparam int OUT_W  = 24;
   localparam int CSR_W  = 32;
   localparam int CSR_AW = 2;
   localparam int QUO_W  = 33;

   // Fixed scale factors
   localparam logic [15:0] RATE_SCALE = 16'd60000;
   localparam logic [15:0] PROG_SCALE = 16'd25600;

   // Register indexes
   localparam logic [CSR_AW-1:0] CSR_STALL_WINDOW = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_STALL_DROP   = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_AMBIENT      = 2'd2;
   localparam logic [CSR_AW-1:0] CSR_SETPOINT     = 2'd3;

   // Register reset values
   localparam logic [TS_W-1:0]   RST_STALL_WINDOW = 32'd60000;
   localparam logic [TEMP_W-1:0] RST_STALL_DROP   = 17'd256;
   localparam logic [TEMP_W-1:0] RST_AMBIENT      = 17'd75520;
   localparam logic [TEMP_W-1:0] RST_SETPOINT     = 17'd19712;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RD,
      ST_CHK,
      ST_MULR,
      ST_DIVR,
      ST_WDR,
      ST_MULP,
      ST_DIVP,
      ST_WDP,
      ST_FIN
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic rd_issue;
      logic rd_check;
      logic mul_rate;
      logic mul_prog;
      logic div_start;
      logic rate_store;
      logic prog_store;
      logic out_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic cnt_ge2;
      logic scan_last;
      logic span_nz;
      logic prog_nz;
      logic div_done;
      logic rsp_busy;
   } sts_type;

   // Sign-magnitude quotient to saturated 24-bit two's complement
   function automatic logic [OUT_W-1:0] sat24(input logic neg, input logic [QUO_W-1:0] q);
      logic [OUT_W-1:0] r;
      if (neg) begin
         if (q >= QUO_W'(33'd8388608)) r = 24'h800000;
         else r = OUT_W'(~q + 33'd1);
      end else begin
         if (q > QUO_W'(33'd8388607)) r = 24'h7FFFFF;
         else r = q[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

### hdl/crsm_div.sv
module crsm_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [crsm_pkg::QUO_W-1:0]   num,
   input  logic [crsm_pkg::TS_W-1:0]    den,
   output logic                         done,
   output logic [crsm_pkg::QUO_W-1:0]   quo
);

   logic [crsm_pkg::QUO_W-1:0] quo_ff, quo_in;
   logic [crsm_pkg::TS_W-1:0]  rem_ff, rem_in;
   logic [crsm_pkg::TS_W-1:0]  den_ff;
   logic [5:0]                 step_ff, step_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [crsm_pkg::TS_W:0]    rem_sh;
   logic                       ge;

   // One restoring step per cycle
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[crsm_pkg::QUO_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? crsm_pkg::TS_W'(rem_sh - {1'b0, den_ff}) : rem_sh[crsm_pkg::TS_W-1:0];
         quo_in  = {quo_ff[crsm_pkg::QUO_W-2:0], ge};
         step_in = step_ff + 6'd1;
         if (step_ff == 6'(crsm_pkg::QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) den_ff <= den;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

### hdl/crsm_ctrl.sv
module crsm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  crsm_pkg::sts_type sts,
   output crsm_pkg::cmd_type cmd
);

   crsm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= crsm_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   // Sequencer: scan, rate division, progress division, output
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         crsm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = crsm_pkg::ST_SETUP;
            end
         end
         crsm_pkg::ST_SETUP: begin
            state_in = sts.cnt_ge2 ? crsm_pkg::ST_RD : crsm_pkg::ST_MULP;
         end
         crsm_pkg::ST_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = crsm_pkg::ST_CHK;
         end
         crsm_pkg::ST_CHK: begin
            cmd.rd_check = 1'b1;
            state_in     = sts.scan_last ? crsm_pkg::ST_MULR : crsm_pkg::ST_RD;
         end
         crsm_pkg::ST_MULR: begin
            cmd.mul_rate = 1'b1;
            state_in     = crsm_pkg::ST_DIVR;
         end
         crsm_pkg::ST_DIVR: begin
            if (sts.span_nz) begin
               cmd.div_start = 1'b1;
               state_in      = crsm_pkg::ST_WDR;
            end else begin
               state_in = crsm_pkg::ST_MULP;
            end
         end
         crsm_pkg::ST_WDR: begin
            if (sts.div_done) begin
               cmd.rate_store = 1'b1;
               state_in       = crsm_pkg::ST_MULP;
            end
         end
         crsm_pkg::ST_MULP: begin
            cmd.mul_prog = 1'b1;
            state_in     = crsm_pkg::ST_DIVP;
         end
         crsm_pkg::ST_DIVP: begin
            if (sts.prog_nz) begin
               cmd.div_start = 1'b1;
               state_in      = crsm_pkg::ST_WDP;
            end else begin
               state_in = crsm_pkg::ST_FIN;
            end
         end
         crsm_pkg::ST_WDP: begin
            if (sts.div_done) begin
               cmd.prog_store = 1'b1;
               state_in       = crsm_pkg::ST_FIN;
            end
         end
         crsm_pkg::ST_FIN: begin
            if (!sts.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in     = crsm_pkg::ST_IDLE;
            end
         end
         default: state_in = crsm_pkg::ST_IDLE;
      endcase
   end

endmodule

### hdl/crsm_dp.sv
module crsm_dp #(
   parameter int HISTORY_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  crsm_pkg::cmd_type               cmd,
   output crsm_pkg::sts_type               sts,
   input  logic                            csr_write,
   input  logic [crsm_pkg::CSR_AW-1:0]     csr_index,
   input  logic [crsm_pkg::CSR_W-1:0]      csr_wdata,
   input  logic [crsm_pkg::TS_W-1:0]       req_timestamp_ms,
   input  logic [crsm_pkg::TEMP_W-1:0]     req_temperature,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [crsm_pkg::OUT_W-1:0] rsp_cooling_rate,
   output logic                            rsp_rate_valid,
   output logic                            rsp_stalled,
   output logic signed [crsm_pkg::OUT_W-1:0] rsp_progress_percent,
   output logic                            rsp_progress_valid
);

   localparam int PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CW = $clog2(HISTORY_DEPTH + 1);
   localparam int EW = crsm_pkg::TS_W + crsm_pkg::TEMP_W;
   localparam int TW = crsm_pkg::TEMP_W;

   // Configuration registers
   logic [crsm_pkg::TS_W-1:0] win_ff;
   logic [TW-1:0]             drop_ff, amb_ff, setp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= crsm_pkg::RST_STALL_WINDOW;
         drop_ff <= crsm_pkg::RST_STALL_DROP;
         amb_ff  <= crsm_pkg::RST_AMBIENT;
         setp_ff <= crsm_pkg::RST_SETPOINT;
      end else if (csr_write) begin
         case (csr_index)
            crsm_pkg::CSR_STALL_WINDOW: win_ff  <= csr_wdata;
            crsm_pkg::CSR_STALL_DROP:   drop_ff <= csr_wdata[TW-1:0];
            crsm_pkg::CSR_AMBIENT:      amb_ff  <= csr_wdata[TW-1:0];
            crsm_pkg::CSR_SETPOINT:     setp_ff <= csr_wdata[TW-1:0];
            default: ;
         endcase
      end
   end

   // History ring: one write, one registered read
   logic [EW-1:0] mem_ff [HISTORY_DEPTH];
   logic [EW-1:0] rd_data_ff;
   logic [PW-1:0] wp_ff, wp_in, rd_ptr_ff;
   logic [CW-1:0] cnt_ff, cnt_in, idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) mem_ff[wp_ff] <= {req_timestamp_ms, req_temperature};
      if (cmd.rd_issue) rd_data_ff <= mem_ff[rd_ptr_ff];
   end

   always_comb begin
      wp_in  = (wp_ff == PW'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + PW'(1);
      cnt_in = (cnt_ff == CW'(HISTORY_DEPTH)) ? cnt_ff : cnt_ff + CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         cnt_ff <= '0;
      end else if (cmd.accept) begin
         wp_ff  <= wp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Newest sample and window start
   logic [crsm_pkg::TS_W-1:0] new_ts_ff, start_ff, old_ts_ff;
   logic [TW-1:0]             new_temp_ff, old_temp_ff, ref_temp_ff;
   logic                      found_ff;
   logic [crsm_pkg::TS_W-1:0] chk_ts;
   logic [TW-1:0]             chk_temp;

   assign chk_ts   = rd_data_ff[EW-1:TW];
   assign chk_temp = rd_data_ff[TW-1:0];

   // Scan from oldest; the newest always lies inside the window
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         new_ts_ff   <= req_timestamp_ms;
         new_temp_ff <= req_temperature;
         ref_temp_ff <= req_temperature;
         start_ff    <= (req_timestamp_ms >= win_ff) ? req_timestamp_ms - win_ff : '0;
         found_ff    <= 1'b0;
         idx_ff      <= '0;
         rd_ptr_ff   <= (cnt_ff == CW'(HISTORY_DEPTH)) ? wp_in : '0;
      end else if (cmd.rd_check) begin
         if (idx_ff == '0) begin
            old_ts_ff   <= chk_ts;
            old_temp_ff <= chk_temp;
         end
         if (!found_ff && chk_ts >= start_ff) begin
            ref_temp_ff <= chk_temp;
            found_ff    <= 1'b1;
         end
         idx_ff    <= idx_ff + CW'(1);
         rd_ptr_ff <= (rd_ptr_ff == PW'(HISTORY_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
   end

   // Shared multiplier, sign-magnitude operands
   logic [crsm_pkg::TS_W-1:0]  span;
   logic [TW-1:0]              d_mag, a_mag, s_mag;
   logic                       d_neg, a_neg, s_neg;
   logic [crsm_pkg::QUO_W-1:0] mul_ff;
   logic [crsm_pkg::TS_W-1:0]  div_den_ff;
   logic                       neg_ff;

   always_comb begin
      span  = new_ts_ff - old_ts_ff;
      d_neg = old_temp_ff < new_temp_ff;
      d_mag = d_neg ? new_temp_ff - old_temp_ff : old_temp_ff - new_temp_ff;
      a_neg = amb_ff < new_temp_ff;
      a_mag = a_neg ? new_temp_ff - amb_ff : amb_ff - new_temp_ff;
      s_neg = amb_ff < setp_ff;
      s_mag = s_neg ? setp_ff - amb_ff : amb_ff - setp_ff;
   end

   // Operands widened to the product width before the multiply
   always_ff @(posedge clock) begin
      if (cmd.mul_rate) begin
         mul_ff     <= {16'd0, d_mag} * crsm_pkg::RATE_SCALE;
         neg_ff     <= d_neg;
         div_den_ff <= span;
      end else if (cmd.mul_prog) begin
         mul_ff     <= {16'd0, a_mag} * crsm_pkg::PROG_SCALE;
         neg_ff     <= a_neg ^ s_neg;
         div_den_ff <= crsm_pkg::TS_W'(s_mag);
      end
   end

   logic                       div_done;
   logic [crsm_pkg::QUO_W-1:0] div_quo;

   crsm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (mul_ff),
      .den   (div_den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Per-request results
   logic [crsm_pkg::OUT_W-1:0] rate_ff, prog_ff;
   logic                       rate_ok_ff, prog_ok_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rate_ff    <= '0;
         rate_ok_ff <= 1'b0;
         prog_ff    <= '0;
         prog_ok_ff <= 1'b0;
      end else if (cmd.rate_store) begin
         rate_ff    <= crsm_pkg::sat24(neg_ff, div_quo);
         rate_ok_ff <= 1'b1;
      end else if (cmd.prog_store) begin
         prog_ff    <= crsm_pkg::sat24(neg_ff, div_quo);
         prog_ok_ff <= 1'b1;
      end
   end

   // Stall: drop from reference to newest below minimum
   logic signed [TW+1:0] drop_diff;
   logic                 stall;

   always_comb begin
      drop_diff = signed'({2'b00, ref_temp_ff}) - signed'({2'b00, new_temp_ff});
      stall     = (cnt_ff >= CW'(2)) && (drop_diff < signed'({2'b00, drop_ff}));
   end

   // Output register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.out_load) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_cooling_rate     <= rate_ff;
         rsp_rate_valid       <= rate_ok_ff;
         rsp_stalled          <= stall;
         rsp_progress_percent <= prog_ff;
         rsp_progress_valid   <= prog_ok_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      sts.cnt_ge2   = cnt_ff >= CW'(2);
      sts.scan_last = idx_ff == cnt_ff - CW'(2);
      sts.span_nz   = span != '0;
      sts.prog_nz   = amb_ff != setp_ff;
      sts.div_done  = div_done;
      sts.rsp_busy  = rsp_valid_ff && !rsp_ready;
   end

`ifndef SYNTH
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(HISTORY_DEPTH))
      else $error("sample count above depth");
   a_wp_bound: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= PW'(HISTORY_DEPTH - 1))
      else $error("write pointer out of range");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("output overwritten while held");
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_check |-> (idx_ff < cnt_ff))
      else $error("scan beyond stored samples");
`endif

endmodule

### hdl/cooling_rate_stall_monitor_core.sv
// Channel  | Handshake            | Payload
// req_     | req_valid/req_ready  | timestamp_ms[31:0], temperature[16:0]
// rsp_     | rsp_valid/rsp_ready  | cooling_rate, rate_valid, stalled, progress_percent,
//          |                      | progress_valid
// csr_     | csr_write            | csr_index[1:0], csr_wdata[31:0]
//
// One request at a time. From acceptance to the output load: a setup state, a scan that
// reads and checks each stored sample but the newest, a rate pass and a progress pass
// (multiply, divider start, 33 divider steps, store; each skipped on a zero divisor, the
// rate pass also with one sample) and an output state. The next request is accepted in
// the cycle after the load. The scan is set by the single read port of the history memory.
// Synchronous reset clears the ring count and pointer; history contents are not cleared.
// A held result does not block the next request; it only delays the final output load.
module cooling_rate_stall_monitor_core #(
   parameter int HISTORY_DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [crsm_pkg::TS_W-1:0]          req_timestamp_ms,
   input  logic [crsm_pkg::TEMP_W-1:0]        req_temperature,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [crsm_pkg::OUT_W-1:0]  rsp_cooling_rate,
   output logic                               rsp_rate_valid,
   output logic                               rsp_stalled,
   output logic signed [crsm_pkg::OUT_W-1:0]  rsp_progress_percent,
   output logic                               rsp_progress_valid,
   input  logic                               csr_write,
   input  logic [crsm_pkg::CSR_AW-1:0]        csr_index,
   input  logic [crsm_pkg::CSR_W-1:0]         csr_wdata
);

   crsm_pkg::cmd_type cmd;
   crsm_pkg::sts_type sts;

   crsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   crsm_dp #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_timestamp_ms     (req_timestamp_ms),
      .req_temperature      (req_temperature),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_cooling_rate     (rsp_cooling_rate),
      .rsp_rate_valid       (rsp_rate_valid),
      .rsp_stalled          (rsp_stalled),
      .rsp_progress_percent (rsp_progress_percent),
      .rsp_progress_valid   (rsp_progress_valid)
   );

endmodule
